>>> sv/dual_chip_lcd_refresh_sequencer_macros.svh
// assertion macros used by the refresh sequencer rtl
// no dependencies; included by lcdrs_back, which carries the concurrent checks
`ifndef DUAL_CHIP_LCD_REFRESH_SEQUENCER_MACROS_SVH
`define DUAL_CHIP_LCD_REFRESH_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define LCDRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdrs check failed");
// expression must never hold
`define LCDRS_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lcdrs check failed");
// antecedent implies consequent in the next cycle
`define LCDRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdrs check failed");
`else
`define LCDRS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LCDRS_ASSERT_NEVER(label, clk, rst, expr)
`define LCDRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/lcdrs_pkg.sv
// shared constants, codes and link types of the refresh sequencer
// no dependencies; imported by the front, back and top rtl modules of the block
package lcdrs_pkg;

   // panel geometry and command queue size
   localparam int COLUMNS_PER_CHIP = 64;
   localparam int PAGES            = 8;
   localparam int QUEUE_DEPTH      = 8;

   // result buffer size behind the execute stage
   localparam int OUT_DEPTH = 3;

   // fixed field widths
   localparam int COL_W        = 7;
   localparam int PAGE_W       = 3;
   localparam int BYTE_W       = 8;
   localparam int CMD_VAL_W    = 6;
   localparam int FRAME_ADDR_W = 10;
   localparam int FRAME_DEPTH  = 1 << FRAME_ADDR_W;
   localparam int CSR_IDX_W    = 2;

   // derived widths
   localparam int SCAN_COL_W = $clog2(COLUMNS_PER_CHIP);
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   // request codes on the input channel
   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_REDRAW = 2'd2,
      REQ_QUEUE  = 2'd3
   } req_code_type;

   // controller command kinds
   typedef enum logic [1:0] {
      CMD_COLUMN     = 2'd0,
      CMD_PAGE       = 2'd1,
      CMD_START_LINE = 2'd2
   } cmd_kind_type;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAGE_BASE   = 2'd0,
      CSR_COLUMN_BASE = 2'd1,
      CSR_START_BASE  = 2'd2
   } csr_index_type;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NOP,
      OP_TICK,
      OP_WRITE,
      OP_REDRAW,
      OP_QUEUE
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [COL_W-1:0]     column;
      logic [PAGE_W-1:0]    page;
      logic [BYTE_W-1:0]    pixel_byte;
      logic [1:0]           redraw_mask;
      logic                 cmd_chip;
      cmd_kind_type         cmd_kind;
      logic [CMD_VAL_W-1:0] cmd_value;
      logic                 busy_left;
      logic                 busy_right;
   } item_type;

   // front to back
   typedef struct packed {
      logic     valid;
      item_type item;
   } item_link_type;

   // back to front
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   // one queued controller command
   typedef struct packed {
      cmd_kind_type         kind;
      logic                 chip;
      logic [CMD_VAL_W-1:0] value;
   } qentry_type;

   // one result item
   typedef struct packed {
      logic              bus_valid;
      logic              bus_chip;
      logic              bus_is_command;
      logic [BYTE_W-1:0] bus_byte;
      logic              redraw_pending;
      logic              queue_overflow;
   } result_type;

endpackage

>>> sv/lcdrs_ram.sv
// generic single write port ram with registered read
// no dependencies; used for the frame store
module lcdrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/lcdrs_front.sv
// front end: accepts items, classifies them and holds them in a two-entry queue
// depends on lcdrs_pkg
module lcdrs_front
   import lcdrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [COL_W-1:0]     req_column,
   input  logic [PAGE_W-1:0]    req_page,
   input  logic [BYTE_W-1:0]    req_pixel_byte,
   input  logic [1:0]           req_redraw_mask,
   input  logic                 req_cmd_chip,
   input  logic [1:0]           req_cmd_kind,
   input  logic [CMD_VAL_W-1:0] req_cmd_value,
   input  logic                 req_busy_left,
   input  logic                 req_busy_right,
   input  back_ctl_type         back_ctl,
   output item_link_type        link
);

   item_type   slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   cls;
   logic       push;

   // classify the incoming item
   always_comb begin
      cls             = '0;
      cls.column      = req_column;
      cls.page        = req_page;
      cls.pixel_byte  = req_pixel_byte;
      cls.redraw_mask = req_redraw_mask;
      cls.cmd_chip    = req_cmd_chip;
      cls.cmd_kind    = cmd_kind_type'(req_cmd_kind);
      cls.cmd_value   = req_cmd_value;
      cls.busy_left   = req_busy_left;
      cls.busy_right  = req_busy_right;
      unique case (req_type)
         REQ_TICK:   cls.op = OP_TICK;
         REQ_WRITE:  cls.op = OP_WRITE;
         REQ_REDRAW: cls.op = OP_REDRAW;
         REQ_QUEUE: begin
            // unknown command kind is dropped silently
            if (req_cmd_kind == CMD_COLUMN || req_cmd_kind == CMD_PAGE ||
                req_cmd_kind == CMD_START_LINE) begin
               cls.op = OP_QUEUE;
            end else begin
               cls.op = OP_NOP;
            end
         end
         default:    cls.op = OP_NOP;
      endcase
   end

   // queue pointers
   assign req_ready = (cnt_ff != 2'd2) && !back_ctl.clearing;
   assign push      = req_valid && req_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = back_ctl.pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(back_ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= cls;
      end
   end

   assign link.valid = (cnt_ff != 2'd0);
   assign link.item  = slot_ff[rd_ff];

endmodule

>>> sv/lcdrs_back.sv
// back end: frame store, redraw scan, command queue and result buffer
// depends on lcdrs_pkg, lcdrs_ram and the assertion macro header
`include "dual_chip_lcd_refresh_sequencer_macros.svh"

module lcdrs_back
   import lcdrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  item_link_type        link,
   output back_ctl_type         back_ctl,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output result_type           rsp_res
);

   // clearing pass
   logic                    clear_ff, clear_in;
   logic [FRAME_ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // configuration
   logic [BYTE_W-1:0] page_base_ff, column_base_ff, start_base_ff;

   // sequencer state
   logic [3:0]            flags_ff, flags_in;
   logic [SCAN_COL_W-1:0] scan_col_ff, scan_col_in;
   logic [PAGE_W-1:0]     scan_page_ff, scan_page_in;
   logic                  active_ff, active_in;

   // command queue
   qentry_type        q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] q_rd_ff, q_rd_in;
   logic [QCNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic              q_we;
   logic [QPTR_W-1:0] q_waddr;
   qentry_type        q_wdata;
   logic [QCNT_W:0]   wpos_sum;
   logic              push_req;
   qentry_type        push_entry;
   qentry_type        head;

   // result stage and output buffer
   logic       s1_valid_ff;
   logic       s1_use_ram_ff, use_ram;
   result_type s1_res_ff, res, out_res;
   result_type o_mem_ff [OUT_DEPTH];
   logic [1:0] o_rd_ff, o_rd_in, o_wr_ff, o_wr_in, o_cnt_ff, o_cnt_in;
   logic [2:0] out_occ;
   logic       o_pop;

   // frame store
   logic                    ram_we;
   logic [FRAME_ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [BYTE_W-1:0]       ram_wdata, ram_rdata;
   logic [COL_W-1:0]        scan_col_abs;

   logic exec;
   logic busy_sel;
   logic wrap_page;
   logic [PAGE_W-1:0] next_page;

   item_type it;
   assign it = link.item;

   // execute when the result path has room for this item
   assign out_occ  = {1'b0, o_cnt_ff} + {2'b00, s1_valid_ff};
   assign exec     = link.valid && !clear_ff && (out_occ < 3'(OUT_DEPTH));
   assign back_ctl.pop      = exec;
   assign back_ctl.clearing = clear_ff;

   assign head = q_mem_ff[q_rd_ff];

   // address of the next display byte of the active chip
   assign scan_col_abs = (active_ff ? COL_W'(COLUMNS_PER_CHIP) : '0) + COL_W'(scan_col_ff);
   assign ram_raddr    = {scan_col_abs, scan_page_ff};
   assign wrap_page    = (scan_page_ff == PAGE_W'(PAGES - 1));
   assign next_page    = wrap_page ? '0 : scan_page_ff + 1'b1;

   // item execution
   always_comb begin
      flags_in     = flags_ff;
      scan_col_in  = scan_col_ff;
      scan_page_in = scan_page_ff;
      active_in    = active_ff;
      q_rd_in      = q_rd_ff;
      q_cnt_in     = q_cnt_ff;
      q_we         = 1'b0;
      q_waddr      = '0;
      q_wdata      = '0;
      push_req     = 1'b0;
      push_entry   = '0;
      res          = '0;
      use_ram      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = clr_addr_ff;
      ram_wdata    = '0;
      busy_sel     = 1'b0;
      wpos_sum     = '0;
      clr_addr_in  = clr_addr_ff;
      clear_in     = clear_ff;

      if (clear_ff) begin
         // zero the frame store one byte a cycle
         ram_we      = 1'b1;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clear_in = 1'b0;
         end
      end else if (exec) begin
         unique case (it.op)
            OP_WRITE: begin
               ram_we    = 1'b1;
               ram_waddr = {it.column, it.page};
               ram_wdata = it.pixel_byte;
            end
            OP_REDRAW: begin
               for (int c = 0; c < 2; c++) begin
                  if (it.redraw_mask[c]) begin
                     if (flags_ff[c]) begin
                        flags_in[c + 2] = 1'b1;
                     end else begin
                        flags_in[c] = 1'b1;
                     end
                  end
               end
            end
            OP_QUEUE: begin
               push_req         = 1'b1;
               push_entry.kind  = it.cmd_kind;
               push_entry.chip  = it.cmd_chip;
               push_entry.value = it.cmd_value;
            end
            OP_TICK: begin
               if (q_cnt_ff != '0) begin
                  // queued command goes first once its chip is idle
                  busy_sel = head.chip ? it.busy_right : it.busy_left;
                  if (!busy_sel) begin
                     res.bus_valid      = 1'b1;
                     res.bus_chip       = head.chip;
                     res.bus_is_command = 1'b1;
                     case (head.kind)
                        CMD_COLUMN: res.bus_byte = column_base_ff | BYTE_W'(head.value);
                        CMD_PAGE:   res.bus_byte = page_base_ff | BYTE_W'(head.value);
                        default:    res.bus_byte = start_base_ff | BYTE_W'(head.value);
                     endcase
                     q_rd_in  = (q_rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_rd_ff + 1'b1;
                     q_cnt_in = q_cnt_ff - 1'b1;
                  end
               end else begin
                  busy_sel = active_ff ? it.busy_right : it.busy_left;
                  if (!flags_ff[{1'b0, active_ff}]) begin
                     // nothing pending here, hand over to the other chip
                     active_in = ~active_ff;
                  end else if (!busy_sel) begin
                     res.bus_valid = 1'b1;
                     res.bus_chip  = active_ff;
                     use_ram       = 1'b1;
                     if (scan_col_ff == SCAN_COL_W'(COLUMNS_PER_CHIP - 1)) begin
                        scan_col_in  = '0;
                        scan_page_in = next_page;
                        if (wrap_page) begin
                           // end of the chip pass retires one redraw
                           active_in = ~active_ff;
                           if (flags_ff[{1'b1, active_ff}]) begin
                              flags_in[{1'b1, active_ff}] = 1'b0;
                           end else begin
                              flags_in[{1'b0, active_ff}] = 1'b0;
                           end
                        end
                        push_req         = 1'b1;
                        push_entry.kind  = CMD_PAGE;
                        push_entry.chip  = active_ff;
                        push_entry.value = CMD_VAL_W'(next_page);
                     end else begin
                        scan_col_in = scan_col_ff + 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase

         // command push, dropped with a flag when the queue is full
         if (push_req) begin
            if (q_cnt_ff >= QCNT_W'(QUEUE_DEPTH)) begin
               res.queue_overflow = 1'b1;
            end else begin
               wpos_sum = (QCNT_W + 1)'(q_rd_ff) + (QCNT_W + 1)'(q_cnt_ff);
               if (wpos_sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
                  wpos_sum = wpos_sum - (QCNT_W + 1)'(QUEUE_DEPTH);
               end
               q_we     = 1'b1;
               q_waddr  = wpos_sum[QPTR_W-1:0];
               q_wdata  = push_entry;
               q_cnt_in = q_cnt_ff + 1'b1;
            end
         end

         res.redraw_pending = |flags_in[1:0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         clr_addr_ff    <= '0;
         flags_ff       <= '0;
         scan_col_ff    <= '0;
         scan_page_ff   <= '0;
         active_ff      <= 1'b0;
         q_rd_ff        <= '0;
         q_cnt_ff       <= '0;
         s1_valid_ff    <= 1'b0;
         page_base_ff   <= 8'd184;
         column_base_ff <= 8'd64;
         start_base_ff  <= 8'd192;
      end else begin
         clear_ff     <= clear_in;
         clr_addr_ff  <= clr_addr_in;
         flags_ff     <= flags_in;
         scan_col_ff  <= scan_col_in;
         scan_page_ff <= scan_page_in;
         active_ff    <= active_in;
         q_rd_ff      <= q_rd_in;
         q_cnt_ff     <= q_cnt_in;
         s1_valid_ff  <= exec;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PAGE_BASE:   page_base_ff   <= csr_wdata;
               CSR_COLUMN_BASE: column_base_ff <= csr_wdata;
               CSR_START_BASE:  start_base_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem_ff[q_waddr] <= q_wdata;
      end
      s1_res_ff     <= res;
      s1_use_ram_ff <= use_ram;
   end

   lcdrs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_DEPTH)
   ) u_frame (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // merge the display byte read from the frame store
   always_comb begin
      out_res = s1_res_ff;
      if (s1_use_ram_ff) begin
         out_res.bus_byte = ram_rdata;
      end
   end

   // output buffer
   assign o_pop     = rsp_valid && rsp_ready;
   assign rsp_valid = (o_cnt_ff != 2'd0);
   assign rsp_res   = o_mem_ff[o_rd_ff];

   always_comb begin
      o_wr_in  = o_wr_ff;
      o_rd_in  = o_rd_ff;
      if (s1_valid_ff) begin
         o_wr_in = (o_wr_ff == 2'(OUT_DEPTH - 1)) ? 2'd0 : o_wr_ff + 2'd1;
      end
      if (o_pop) begin
         o_rd_in = (o_rd_ff == 2'(OUT_DEPTH - 1)) ? 2'd0 : o_rd_ff + 2'd1;
      end
      o_cnt_in = o_cnt_ff + 2'(s1_valid_ff) - 2'(o_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_rd_ff  <= '0;
         o_wr_ff  <= '0;
         o_cnt_ff <= '0;
      end else begin
         o_rd_ff  <= o_rd_in;
         o_wr_ff  <= o_wr_in;
         o_cnt_ff <= o_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         o_mem_ff[o_wr_ff] <= out_res;
      end
   end

   // checks
   `LCDRS_ASSERT_NEVER(a_qcnt_bound, clock, reset, q_cnt_ff > QCNT_W'(QUEUE_DEPTH))
   `LCDRS_ASSERT_NEVER(a_no_exec_in_clear, clock, reset, clear_ff && exec)
   `LCDRS_ASSERT_NEVER(a_out_room, clock, reset, out_occ > 3'(OUT_DEPTH))
   `LCDRS_ASSERT_IMPL(a_ram_byte_is_data, clock, reset, s1_valid_ff && s1_use_ram_ff, s1_res_ff.bus_valid && !s1_res_ff.bus_is_command)
   `LCDRS_ASSERT_NEXT(a_exec_reaches_s1, clock, reset, exec, s1_valid_ff)

endmodule

>>> sv/dual_chip_lcd_refresh_sequencer.sv
// top level of the two-chip graphic lcd refresh sequencer
// depends on lcdrs_pkg, lcdrs_front and lcdrs_back
//
// Sustains one item per clock, unless the result side stalls, with one result
// item per accepted item, in order; an item passes the front queue, then
// execute with frame store read, then the result merge into the output
// buffer. Two small queues part the sides, so input and output stall
// independently. After reset the 1024-byte frame store is zeroed one byte a
// cycle, and req_ready stays low until it is done; configuration writes are
// taken throughout. The frame store's single read port and the one bus write
// decided per tick set the one item per cycle figure.
module dual_chip_lcd_refresh_sequencer
   import lcdrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [COL_W-1:0]     req_column,
   input  logic [PAGE_W-1:0]    req_page,
   input  logic [BYTE_W-1:0]    req_pixel_byte,
   input  logic [1:0]           req_redraw_mask,
   input  logic                 req_cmd_chip,
   input  logic [1:0]           req_cmd_kind,
   input  logic [CMD_VAL_W-1:0] req_cmd_value,
   input  logic                 req_busy_left,
   input  logic                 req_busy_right,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_bus_valid,
   output logic                 rsp_bus_chip,
   output logic                 rsp_bus_is_command,
   output logic [BYTE_W-1:0]    rsp_bus_byte,
   output logic                 rsp_redraw_pending,
   output logic                 rsp_queue_overflow
);

   item_link_type link;
   back_ctl_type  back_ctl;
   result_type    rsp_res;

   lcdrs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_column      (req_column),
      .req_page        (req_page),
      .req_pixel_byte  (req_pixel_byte),
      .req_redraw_mask (req_redraw_mask),
      .req_cmd_chip    (req_cmd_chip),
      .req_cmd_kind    (req_cmd_kind),
      .req_cmd_value   (req_cmd_value),
      .req_busy_left   (req_busy_left),
      .req_busy_right  (req_busy_right),
      .back_ctl        (back_ctl),
      .link            (link)
   );

   lcdrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .link      (link),
      .back_ctl  (back_ctl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (rsp_res)
   );

   // result fields onto their ports
   assign rsp_bus_valid      = rsp_res.bus_valid;
   assign rsp_bus_chip       = rsp_res.bus_chip;
   assign rsp_bus_is_command = rsp_res.bus_is_command;
   assign rsp_bus_byte       = rsp_res.bus_byte;
   assign rsp_redraw_pending = rsp_res.redraw_pending;
   assign rsp_queue_overflow = rsp_res.queue_overflow;

endmodule

>>> sim/dual_chip_lcd_refresh_sequencer_test.sv
// self-checking testbench for the two-chip lcd refresh sequencer
// needs lcdrs_pkg and the rtl of dual_chip_lcd_refresh_sequencer, nothing else
// a directed item table runs first, then random phases under several opcode bases
module dual_chip_lcd_refresh_sequencer_test
   import lcdrs_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_UNKNOWN   = 2'd3;
   localparam int         PHASE_ITEMS    = 360;
   localparam int         WATCHDOG_LIMIT = 4000;
   localparam int         HOLD_AT        = 500;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         TAIL_CYCLES    = 10;

   // one input item as offered on the request channel
   typedef struct packed {
      req_code_type         kind;
      logic [COL_W-1:0]     column;
      logic [PAGE_W-1:0]    page;
      logic [BYTE_W-1:0]    pixel_byte;
      logic [1:0]           redraw_mask;
      logic                 cmd_chip;
      logic [1:0]           cmd_kind;
      logic [CMD_VAL_W-1:0] cmd_value;
      logic                 busy_left;
      logic                 busy_right;
   } panel_req_type;

   // directed row: item plus, where obvious, the bus write it must give
   typedef struct {
      panel_req_type req;
      bit            known;
      result_type    want;
   } plan_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_type;
   logic [COL_W-1:0]     req_column;
   logic [PAGE_W-1:0]    req_page;
   logic [BYTE_W-1:0]    req_pixel_byte;
   logic [1:0]           req_redraw_mask;
   logic                 req_cmd_chip;
   logic [1:0]           req_cmd_kind;
   logic [CMD_VAL_W-1:0] req_cmd_value;
   logic                 req_busy_left;
   logic                 req_busy_right;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_bus_valid;
   logic                 rsp_bus_chip;
   logic                 rsp_bus_is_command;
   logic [BYTE_W-1:0]    rsp_bus_byte;
   logic                 rsp_redraw_pending;
   logic                 rsp_queue_overflow;

   // mirror of the panel refresh state
   logic [BYTE_W-1:0]     frame_mirror [FRAME_DEPTH];
   logic [3:0]            redraw_bits;
   logic [SCAN_COL_W-1:0] scan_col;
   logic [PAGE_W-1:0]     scan_pg;
   logic                  active_side;
   qentry_type            cmd_ring [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     ring_rd;
   logic [QCNT_W-1:0]     ring_count;
   logic [BYTE_W-1:0]     page_base;
   logic [BYTE_W-1:0]     column_base;
   logic [BYTE_W-1:0]     start_base;

   result_type   bus_expect [$];
   plan_row_type plan [$];
   int           items_sent;
   int           results_seen;
   int           mismatches;
   int           quiet_cycles;
   int           data_writes;
   int           cmd_writes;
   int           dropped_cmds;

   dual_chip_lcd_refresh_sequencer DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_column         (req_column),
      .req_page           (req_page),
      .req_pixel_byte     (req_pixel_byte),
      .req_redraw_mask    (req_redraw_mask),
      .req_cmd_chip       (req_cmd_chip),
      .req_cmd_kind       (req_cmd_kind),
      .req_cmd_value      (req_cmd_value),
      .req_busy_left      (req_busy_left),
      .req_busy_right     (req_busy_right),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bus_valid      (rsp_bus_valid),
      .rsp_bus_chip       (rsp_bus_chip),
      .rsp_bus_is_command (rsp_bus_is_command),
      .rsp_bus_byte       (rsp_bus_byte),
      .rsp_redraw_pending (rsp_redraw_pending),
      .rsp_queue_overflow (rsp_queue_overflow)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // item builders: fields the item kind does not use carry random noise
   function automatic panel_req_type noise_req();
      panel_req_type r;
      r.kind        = REQ_TICK;
      r.column      = COL_W'($urandom);
      r.page        = PAGE_W'($urandom);
      r.pixel_byte  = BYTE_W'($urandom);
      r.redraw_mask = 2'($urandom);
      r.cmd_chip    = 1'($urandom);
      r.cmd_kind    = 2'($urandom);
      r.cmd_value   = CMD_VAL_W'($urandom);
      r.busy_left   = 1'($urandom);
      r.busy_right  = 1'($urandom);
      return r;
   endfunction

   function automatic panel_req_type req_tick(input logic bl, input logic br);
      panel_req_type r;
      r            = noise_req();
      r.kind       = REQ_TICK;
      r.busy_left  = bl;
      r.busy_right = br;
      return r;
   endfunction

   function automatic panel_req_type req_write(input int col, input int pg, input int b);
      panel_req_type r;
      r            = noise_req();
      r.kind       = REQ_WRITE;
      r.column     = COL_W'(col);
      r.page       = PAGE_W'(pg);
      r.pixel_byte = BYTE_W'(b);
      return r;
   endfunction

   function automatic panel_req_type req_redraw(input logic [1:0] mask);
      panel_req_type r;
      r             = noise_req();
      r.kind        = REQ_REDRAW;
      r.redraw_mask = mask;
      return r;
   endfunction

   function automatic panel_req_type req_queue(input logic chip, input logic [1:0] kind,
                                               input int value);
      panel_req_type r;
      r           = noise_req();
      r.kind      = REQ_QUEUE;
      r.cmd_chip  = chip;
      r.cmd_kind  = kind;
      r.cmd_value = CMD_VAL_W'(value);
      return r;
   endfunction

   function automatic panel_req_type random_command();
      logic [1:0] kind;
      kind = ($urandom_range(0, 7) == 0) ? KIND_UNKNOWN : 2'($urandom_range(0, 2));
      return req_queue(1'($urandom), kind, $urandom_range(0, 63));
   endfunction

   // random mix; tick_share is the percentage of ticks
   function automatic panel_req_type random_req(input int tick_share);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < tick_share)
         return req_tick($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
      roll = $urandom_range(0, 19);
      if (roll < 9)
         return req_write($urandom_range(0, 127), $urandom_range(0, 7), $urandom_range(0, 255));
      if (roll < 13)
         return req_redraw(2'($urandom_range(0, 3)));
      return random_command();
   endfunction

   function automatic result_type bus_result(input int v, input int c, input int k,
                                             input logic [BYTE_W-1:0] b, input int p,
                                             input int o);
      return {1'(v), 1'(c), 1'(k), b, 1'(p), 1'(o)};
   endfunction

   // command ring push; returns 1 when the ring is full and the command is lost
   function automatic logic ring_push(input logic cmd_side, input cmd_kind_type cmd_op,
                                      input logic [CMD_VAL_W-1:0] cmd_arg);
      logic [QPTR_W-1:0] slot;
      if (ring_count >= QUEUE_DEPTH)
         return 1'b1;
      slot           = ring_rd + QPTR_W'(ring_count);
      cmd_ring[slot] = '{kind: cmd_op, chip: cmd_side, value: cmd_arg};
      ring_count     = ring_count + 1'b1;
      return 1'b0;
   endfunction

   // advance the mirrored panel state by one item and give the bus write it causes
   function automatic result_type advance_panel(input panel_req_type r);
      result_type        res;
      qentry_type        head;
      logic              side;
      logic [1:0]        side_busy;
      logic [BYTE_W-1:0] opcode_base;
      res       = '0;
      side_busy = {r.busy_right, r.busy_left};
      case (r.kind)
         REQ_WRITE: begin
            frame_mirror[{r.column, r.page}] = r.pixel_byte;
         end
         REQ_REDRAW: begin
            // a second request per chip is remembered, further ones saturate
            for (int s = 0; s < 2; s++) begin
               if (r.redraw_mask[s]) begin
                  if (redraw_bits[s])
                     redraw_bits[s + 2] = 1'b1;
                  else
                     redraw_bits[s] = 1'b1;
               end
            end
         end
         REQ_QUEUE: begin
            if (r.cmd_kind != KIND_UNKNOWN)
               res.queue_overflow = ring_push(r.cmd_chip, cmd_kind_type'(r.cmd_kind),
                                              r.cmd_value);
         end
         default: begin
            if (ring_count != 0) begin
               // queued command first, only when its chip is idle
               head = cmd_ring[ring_rd];
               if (!side_busy[head.chip]) begin
                  case (head.kind)
                     CMD_COLUMN: opcode_base = column_base;
                     CMD_PAGE:   opcode_base = page_base;
                     default:    opcode_base = start_base;
                  endcase
                  res.bus_valid      = 1'b1;
                  res.bus_chip       = head.chip;
                  res.bus_is_command = 1'b1;
                  res.bus_byte       = opcode_base | {2'b00, head.value};
                  ring_rd            = ring_rd + 1'b1;
                  ring_count         = ring_count - 1'b1;
               end
            end else begin
               side = active_side;
               if (!redraw_bits[side]) begin
                  active_side = ~side;
               end else if (!side_busy[side]) begin
                  res.bus_valid = 1'b1;
                  res.bus_chip  = side;
                  res.bus_byte  = frame_mirror[{side, scan_col, scan_pg}];
                  scan_col      = scan_col + 1'b1;
                  // page wrap, and at the end of the pass hand over to the other chip
                  if (scan_col == 0) begin
                     scan_pg = scan_pg + 1'b1;
                     if (scan_pg == 0) begin
                        active_side = ~side;
                        if (redraw_bits[int'(side) + 2])
                           redraw_bits[int'(side) + 2] = 1'b0;
                        else
                           redraw_bits[side] = 1'b0;
                     end
                     res.queue_overflow = ring_push(side, CMD_PAGE, {3'b000, scan_pg});
                  end
               end
            end
         end
      endcase
      res.redraw_pending = |redraw_bits[1:0];
      return res;
   endfunction

   task automatic add_row(input panel_req_type r, input bit known, input result_type want);
      plan_row_type row;
      row.req   = r;
      row.known = known;
      row.want  = want;
      plan.push_back(row);
   endtask

   // offer one item after a random gap, hold it until taken, then note its bus write
   task automatic send_item(input panel_req_type r, input bit known, input result_type want);
      int         gap;
      result_type predicted;
      gap = (items_sent % 100 < 30) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type        <= r.kind;
      req_column      <= r.column;
      req_page        <= r.page;
      req_pixel_byte  <= r.pixel_byte;
      req_redraw_mask <= r.redraw_mask;
      req_cmd_chip    <= r.cmd_chip;
      req_cmd_kind    <= r.cmd_kind;
      req_cmd_value   <= r.cmd_value;
      req_busy_left   <= r.busy_left;
      req_busy_right  <= r.busy_right;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      predicted = advance_panel(r);
      bus_expect.push_back(known ? want : predicted);
      items_sent++;
      if (predicted.bus_valid && predicted.bus_is_command)
         cmd_writes++;
      else if (predicted.bus_valid)
         data_writes++;
      if (predicted.queue_overflow)
         dropped_cmds++;
      @(negedge clock);
   endtask

   // stop offering and wait until every bus write has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (bus_expect.size() != 0)
         @(negedge clock);
   endtask

   // program all three opcode bases, block idle
   task automatic program_bases(input logic [BYTE_W-1:0] p, input logic [BYTE_W-1:0] c,
                                input logic [BYTE_W-1:0] s);
      csr_we    <= 1'b1;
      csr_index <= CSR_PAGE_BASE;
      csr_wdata <= p;
      @(negedge clock);
      csr_index <= CSR_COLUMN_BASE;
      csr_wdata <= c;
      @(negedge clock);
      csr_index <= CSR_START_BASE;
      csr_wdata <= s;
      @(negedge clock);
      csr_we      <= 1'b0;
      page_base   = p;
      column_base = c;
      start_base  = s;
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // stimulus
   initial begin
      int tick_share [4];
      int remaining;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_PAGE_BASE;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_type        = REQ_TICK;
      req_column      = '0;
      req_page        = '0;
      req_pixel_byte  = '0;
      req_redraw_mask = '0;
      req_cmd_chip    = 1'b0;
      req_cmd_kind    = CMD_COLUMN;
      req_cmd_value   = '0;
      req_busy_left   = 1'b0;
      req_busy_right  = 1'b0;
      items_sent      = 0;
      mismatches      = 0;
      data_writes     = 0;
      cmd_writes      = 0;
      dropped_cmds    = 0;
      tick_share      = '{65, 90, 70, 80};

      // mirror starts from the reset state
      foreach (frame_mirror[i])
         frame_mirror[i] = '0;
      redraw_bits = '0;
      scan_col    = '0;
      scan_pg     = '0;
      active_side = 1'b0;
      ring_rd     = '0;
      ring_count  = '0;
      page_base   = 8'd184;
      column_base = 8'd64;
      start_base  = 8'd192;

      // directed items under the reset opcode bases
      add_row(req_tick(1'b0, 1'b0), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_write(0, 0, 8'hFF), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_write(127, 7, 8'h80), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_write(64, 0, 8'h5A), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_queue(1'b0, CMD_COLUMN, 63), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_queue(1'b1, KIND_UNKNOWN, 21), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_tick(1'b1, 1'b0), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_tick(1'b0, 1'b1), 1'b1, bus_result(1, 0, 1, 8'd127, 0, 0));
      add_row(req_queue(1'b1, CMD_PAGE, 7), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_queue(1'b1, CMD_START_LINE, 0), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_tick(1'b1, 1'b1), 1'b1, bus_result(0, 0, 0, 8'd0, 0, 0));
      add_row(req_tick(1'b1, 1'b0), 1'b1, bus_result(1, 1, 1, 8'd191, 0, 0));
      add_row(req_tick(1'b0, 1'b0), 1'b1, bus_result(1, 1, 1, 8'd192, 0, 0));
      add_row(req_redraw(2'b11), 1'b1, bus_result(0, 0, 0, 8'd0, 1, 0));
      add_row(req_redraw(2'b01), 1'b1, bus_result(0, 0, 0, 8'd0, 1, 0));
      add_row(req_redraw(2'b11), 1'b1, bus_result(0, 0, 0, 8'd0, 1, 0));
      add_row(req_tick(1'b0, 1'b0), 1'b0, '0);
      add_row(req_tick(1'b0, 1'b1), 1'b0, '0);
      // fill the command ring, the ninth command is dropped
      for (int i = 0; i < 9; i++)
         add_row(req_queue(1'(i), 2'(i % 3), (i == 0) ? 63 : i * 7), 1'b1,
                 bus_result(0, 0, 0, 8'd0, 1, int'(i == 8)));

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      foreach (plan[i])
         send_item(plan[i].req, plan[i].known, plan[i].want);

      // random phases, each under its own opcode bases
      for (int ph = 0; ph < 4; ph++) begin
         settle();
         case (ph)
            0:       program_bases(8'h00, 8'h00, 8'h00);
            1:       program_bases(8'hFF, 8'hFF, 8'hFF);
            default: program_bases(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         remaining = PHASE_ITEMS;
         while (remaining > 0) begin
            if ($urandom_range(0, 59) == 0) begin
               // burst of host commands to run the ring full
               repeat (10) begin
                  send_item(random_command(), 1'b0, '0);
                  remaining--;
               end
            end else begin
               send_item(random_req(tick_share[ph]), 1'b0, '0);
               remaining--;
            end
         end
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d items and %0d results: %0d frame bytes, %0d commands on the bus",
               items_sent, results_seen, data_writes, cmd_writes);
      $display("%0d commands dropped on a full ring, opcode bases at reset, zero, ones, random",
               dropped_cmds);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // result side: random stalls, calm stretches and one long hold-off
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (results_seen == HOLD_AT)
            stall = HOLD_CYCLES;
         else if (results_seen % 90 < 25)
            stall = 0;
         else
            stall = $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // compare each result item with the oldest expected bus write
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         got = {rsp_bus_valid, rsp_bus_chip, rsp_bus_is_command, rsp_bus_byte,
                rsp_redraw_pending, rsp_queue_overflow};
         if (bus_expect.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = bus_expect.pop_front();
            check_field("bus_valid", 32'(want.bus_valid), 32'(got.bus_valid));
            check_field("bus_chip", 32'(want.bus_chip), 32'(got.bus_chip));
            check_field("bus_is_command", 32'(want.bus_is_command),
                        32'(got.bus_is_command));
            check_field("bus_byte", 32'(want.bus_byte), 32'(got.bus_byte));
            check_field("redraw_pending", 32'(want.redraw_pending),
                        32'(got.redraw_pending));
            check_field("queue_overflow", 32'(want.queue_overflow),
                        32'(got.queue_overflow));
         end
      end
   end

   // watchdog on cycles without any item moving
   initial results_seen = 0;
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ns: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

>>> dual_chip_lcd_refresh_sequencer.f
+incdir+sv
sv/lcdrs_pkg.sv
sv/lcdrs_ram.sv
sv/lcdrs_front.sv
sv/lcdrs_back.sv
sv/dual_chip_lcd_refresh_sequencer.sv
sim/dual_chip_lcd_refresh_sequencer_test.sv
